// File: hw/rtl/mapf_pkg.sv
// Shared types and constants for the moving-average process filter.
// No dependencies; imported by mapf_cell, the filter top level, the checker and the testbench.
package mapf_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int TAP_CNT_W  = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = SAMPLE_W + COEF_W;

    // Default delay line length and number of coefficient registers
    localparam int MAX_TAPS_DEF = 6;
    localparam int COEF_REGS    = 6;

    // Fixed point: Q4.12 samples times Q2.14 weights, sum kept at Q.26
    localparam int FRAC_SHIFT = 14;
    localparam int ROUND_HALF = 8192;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TAP_COUNT  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_FIRST = 3'd1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // Per-cell control
    typedef struct packed {
        logic clear;   // zero the stored sample
        logic shift;   // take the neighbor's sample
        logic tap_en;  // this tap contributes to the sum
    } t_cell_ctl;

endpackage

// File: hw/rtl/mapf_cell.sv
// One cell of the delay-line chain: holds one past sample and, when its tap is
// enabled, adds its weighted value to the partial sum moving through. Depends on mapf_pkg.
module mapf_cell import mapf_pkg::*; #(
    parameter int ACC_W = 35
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cell_ctl                  i_ctl,
    input  logic signed [COEF_W-1:0]   i_coef,
    input  logic signed [SAMPLE_W-1:0] i_hist,
    output logic signed [SAMPLE_W-1:0] o_hist,
    input  logic signed [ACC_W-1:0]    i_sum,
    input  logic                       i_sum_vld,
    output logic signed [ACC_W-1:0]    o_sum,
    output logic                       o_sum_vld
);

    logic signed [SAMPLE_W-1:0] r_hist;
    logic signed [ACC_W-1:0]    r_sum;
    logic                       r_sum_vld;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [ACC_W-1:0]    n_sum;

    // Hold the stored sample; clear on a new sequence, advance on shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_hist <= '0;
        end else if (i_ctl.shift) begin
            r_hist <= i_hist;
        end
    end

    // Weight the stored sample and add it to the passing sum
    always_comb begin
        w_prod = i_coef * r_hist;
        n_sum  = i_sum;
        if (i_ctl.tap_en) begin
            n_sum = i_sum + ACC_W'(w_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= 1'b0;
        end else begin
            r_sum_vld <= i_sum_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_hist    = r_hist;
    assign o_sum     = r_sum;
    assign o_sum_vld = r_sum_vld;

endmodule

// File: hw/rtl/moving_average_process_filter_top.sv
// Moving-average process filter MA(q): y = x + sum coef_k * x[n-k], Q4.12
// samples, Q2.14 weights, rounded half up and saturated to 16 bits. One word
// is taken at a time: the seeded sum walks down a chain of MAX_TAPS cells,
// one cell per cycle, each of the first q cells adding its own tap, then gets
// rounded and registered before the next word is accepted. A finished
// result waits in the output register while the next word is accepted.
// A start flag zeroes the delay line; the first q words of a sequence pass
// through unchanged. Depends on mapf_pkg and mapf_cell.
module moving_average_process_filter_top import mapf_pkg::*; #(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration writes
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]        i_cfg_wdata,
    // input words
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [SAMPLE_W-1:0]   i_noise_sample,
    input  logic                         i_start_sequence,
    // result words
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [SAMPLE_W-1:0]   o_filtered_sample,
    output logic                         o_saturated
);

    localparam int QW    = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = PROD_W + $clog2(MAX_TAPS + 1);
    localparam int RW    = ACC_W - FRAC_SHIFT;

    // Configuration registers
    logic [TAP_CNT_W-1:0]     r_tap_count;
    logic signed [COEF_W-1:0] r_coef [COEF_REGS];

    // Sequencer and word registers
    t_state                     r_state, n_state;
    logic [QW-1:0]              r_warm, n_warm, w_warm_eff, w_q;
    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_pass;
    logic signed [ACC_W-1:0]    r_seed, n_seed;
    logic                       r_seed_vld;
    logic signed [SAMPLE_W-1:0] r_res;
    logic                       r_res_sat;
    logic signed [SAMPLE_W-1:0] r_out;
    logic                       r_out_sat;
    logic                       r_out_valid;

    logic w_accept, w_fin, w_slot_free, w_load_out, w_pass;

    // Chain links
    logic signed [SAMPLE_W-1:0] w_hist [MAX_TAPS+1];
    logic signed [ACC_W-1:0]    w_sum  [MAX_TAPS+1];
    logic                       w_vld  [MAX_TAPS+1];
    t_cell_ctl                  w_ctl  [MAX_TAPS];

    // Rounding and saturation
    logic signed [RW-1:0]       w_round;
    logic                       w_ovf;
    logic signed [SAMPLE_W-1:0] n_res;
    logic                       n_res_sat;

    // Write configuration registers; ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= '0;
            for (int j = 0; j < COEF_REGS; j++) begin
                r_coef[j] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            if (i_cfg_addr == REG_TAP_COUNT) begin
                r_tap_count <= i_cfg_wdata[TAP_CNT_W-1:0];
            end
            for (int j = 0; j < COEF_REGS; j++) begin
                if (i_cfg_addr == REG_COEF_FIRST + CFG_ADDR_W'(j)) begin
                    r_coef[j] <= i_cfg_wdata;
                end
            end
        end
    end

    // Effective order, clamped to the chain length
    always_comb begin
        if (int'(r_tap_count) > MAX_TAPS) begin
            w_q = QW'(MAX_TAPS);
        end else begin
            w_q = QW'(r_tap_count);
        end
    end

    // Warm-up bookkeeping for the incoming word
    always_comb begin
        w_warm_eff = i_start_sequence ? '0 : r_warm;
        w_pass     = (w_warm_eff < w_q);
        if (w_warm_eff == QW'(MAX_TAPS)) begin
            n_warm = w_warm_eff;
        end else begin
            n_warm = w_warm_eff + 1'b1;
        end
        n_seed = (ACC_W'(i_noise_sample) <<< FRAC_SHIFT) + ACC_W'(ROUND_HALF);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_fin) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_RUN:  o_in_stall = 1'b1;
            ST_DONE: w_load_out = w_slot_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_fin       = w_vld[MAX_TAPS];
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_warm     <= '0;
            r_seed_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_seed_vld <= w_accept;
            if (w_accept) begin
                r_warm <= n_warm;
            end
        end
    end

    // Latch the word and seed the sum
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x    <= i_noise_sample;
            r_pass <= w_pass;
            r_seed <= n_seed;
        end
    end

    // Chain ends
    assign w_hist[0] = r_x;
    assign w_sum[0]  = r_seed;
    assign w_vld[0]  = r_seed_vld;

    // Build the cell chain
    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        logic signed [COEF_W-1:0] w_coef;

        if (k < COEF_REGS) begin : g_weighted
            assign w_coef = r_coef[k];
        end else begin : g_unweighted
            assign w_coef = '0;
        end

        assign w_ctl[k].clear  = w_accept && i_start_sequence;
        assign w_ctl[k].shift  = w_fin;
        assign w_ctl[k].tap_en = (QW'(k) < w_q);

        mapf_cell #(
            .ACC_W (ACC_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl[k]),
            .i_coef    (w_coef),
            .i_hist    (w_hist[k]),
            .o_hist    (w_hist[k+1]),
            .i_sum     (w_sum[k]),
            .i_sum_vld (w_vld[k]),
            .o_sum     (w_sum[k+1]),
            .o_sum_vld (w_vld[k+1])
        );
    end

    // Round half up, then clip to 16 bits
    always_comb begin
        w_round   = RW'(w_sum[MAX_TAPS] >>> FRAC_SHIFT);
        w_ovf     = (w_round[RW-1:SAMPLE_W-1] != '0) && (w_round[RW-1:SAMPLE_W-1] != '1);
        n_res     = w_round[SAMPLE_W-1:0];
        n_res_sat = 1'b0;
        if (r_pass) begin
            n_res = r_x;
        end else if (w_ovf) begin
            n_res_sat = 1'b1;
            n_res     = w_round[RW-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                      : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_res     <= n_res;
            r_res_sat <= n_res_sat;
        end
    end

    // Output register: load when free, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out     <= r_res;
            r_out_sat <= r_res_sat;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_filtered_sample = r_out;
    assign o_saturated       = r_out_sat;

endmodule

// File: dv/moving_average_process_filter_checker.sv
`timescale 1ns / 100ps
// Checker for the moving-average process filter: tracks register writes,
// predicts every result word and compares it with what the filter sends.
// Depends on mapf_pkg; instantiated beside the filter by the testbench top.
module moving_average_process_filter_checker import mapf_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic signed [SAMPLE_W-1:0]  i_noise_sample,
    input  logic                        i_start_sequence,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic signed [SAMPLE_W-1:0]  i_filtered_sample,
    input  logic                        i_saturated,
    output int                          o_errors,
    output int                          o_pending
);

    localparam longint SUM_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SUM_MIN = -(longint'(1) <<< (SAMPLE_W - 1));

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } t_ma_word;

    // Shadow copy of the registers and the delay line
    logic [TAP_CNT_W-1:0]       order_reg;
    logic signed [COEF_W-1:0]   weight [COEF_REGS];
    logic signed [SAMPLE_W-1:0] past [MAX_TAPS_DEF];
    int                         warm;

    t_ma_word ma_expected [$];

    // Filter one sample and advance the delay line
    function automatic t_ma_word ma_step(input logic signed [SAMPLE_W-1:0] x,
                                         input logic st);
        int       order;
        longint   acc;
        longint   rounded;
        t_ma_word y;
        order = (order_reg > MAX_TAPS_DEF) ? MAX_TAPS_DEF : int'(order_reg);
        if (st) begin
            foreach (past[k]) past[k] = '0;
            warm = 0;
        end
        y.clipped = 1'b0;
        if (warm < order) begin
            y.sample = x;
        end else begin
            acc = longint'(x) * (longint'(1) <<< FRAC_SHIFT);
            for (int k = 0; k < order; k++) begin
                if (k < COEF_REGS) acc += longint'(weight[k]) * longint'(past[k]);
            end
            // round half up, then clip to the sample range
            rounded = (acc + ROUND_HALF) >>> FRAC_SHIFT;
            if (rounded > SUM_MAX) begin
                rounded = SUM_MAX;
                y.clipped = 1'b1;
            end else if (rounded < SUM_MIN) begin
                rounded = SUM_MIN;
                y.clipped = 1'b1;
            end
            y.sample = rounded[SAMPLE_W-1:0];
        end
        for (int k = MAX_TAPS_DEF - 1; k > 0; k--) past[k] = past[k-1];
        past[0] = x;
        if (warm < MAX_TAPS_DEF) warm++;
        return y;
    endfunction

    always @(posedge i_clk) begin
        t_ma_word want;
        if (!i_rst_n) begin
            order_reg = '0;
            foreach (weight[k]) weight[k] = '0;
            foreach (past[k]) past[k] = '0;
            warm = 0;
            ma_expected.delete();
            o_errors = 0;
            o_pending <= 0;
        end else begin
            // track register writes; spare indexes are dropped
            if (i_cfg_wr_en) begin
                if (i_cfg_addr == REG_TAP_COUNT) begin
                    order_reg = i_cfg_wdata[TAP_CNT_W-1:0];
                end else if (i_cfg_addr >= REG_COEF_FIRST &&
                             int'(i_cfg_addr) < int'(REG_COEF_FIRST) + COEF_REGS) begin
                    weight[i_cfg_addr - REG_COEF_FIRST] = i_cfg_wdata;
                end
            end
            // predict each accepted sample word
            if (i_in_valid && !i_in_stall) begin
                ma_expected.push_back(ma_step(i_noise_sample, i_start_sequence));
            end
            // compare each accepted result word with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (ma_expected.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %0d / %0b",
                             $time, i_filtered_sample, i_saturated);
                    o_errors++;
                end else begin
                    want = ma_expected.pop_front();
                    if (want.sample !== i_filtered_sample) begin
                        $display("%0t: filtered_sample expected %0d, got %0d",
                                 $time, $signed(want.sample), i_filtered_sample);
                        o_errors++;
                    end
                    if (want.clipped !== i_saturated) begin
                        $display("%0t: saturated expected %0b, got %0b",
                                 $time, want.clipped, i_saturated);
                        o_errors++;
                    end
                end
            end
            o_pending <= ma_expected.size();
        end
    end

endmodule

// File: dv/moving_average_process_filter_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the moving-average process filter: clock, reset,
// register loads, sample stimulus and receiver stalls, and the verdict.
// Depends on mapf_pkg, the filter top level and the checker module.
module moving_average_process_filter_top_tb import mapf_pkg::*; ();

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = MAX_TAPS_DEF + 6;
    localparam int PHASE_WORDS = 222;
    localparam int RAND_PHASES = 8;

    localparam logic [CFG_ADDR_W-1:0]  REG_SPARE  = 3'd7;
    localparam logic signed [SAMPLE_W-1:0] NOISE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] NOISE_MIN = 16'sh8000;
    localparam logic signed [COEF_W-1:0]   COEF_MAX  = 16'sh7FFF;
    localparam logic signed [COEF_W-1:0]   COEF_MIN  = 16'sh8000;
    localparam logic signed [COEF_W-1:0]   COEF_HALF = 16'sh2000;

    logic                       i_clk;
    logic                       i_rst_n          = 1'b0;
    logic                       cfg_wr_en        = 1'b0;
    logic [CFG_ADDR_W-1:0]      cfg_addr         = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata        = '0;
    logic                       in_valid         = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] noise_sample     = '0;
    logic                       start_sequence   = 1'b0;
    logic                       out_valid;
    logic                       out_stall        = 1'b0;
    logic signed [SAMPLE_W-1:0] filtered_sample;
    logic                       saturated;

    int errors;
    int pending;
    int cycles    = 0;
    int stall_left = 0;
    int stall_draw;
    bit quiet     = 1'b0;

    logic signed [COEF_W-1:0] weights_next [COEF_REGS];

    moving_average_process_filter_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_addr        (cfg_addr),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_noise_sample    (noise_sample),
        .i_start_sequence  (start_sequence),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_filtered_sample (filtered_sample),
        .o_saturated       (saturated)
    );

    moving_average_process_filter_checker u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_addr        (cfg_addr),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_noise_sample    (noise_sample),
        .i_start_sequence  (start_sequence),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_filtered_sample (filtered_sample),
        .i_saturated       (saturated),
        .o_errors          (errors),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Hold off each result word for a random number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (out_valid && !out_stall) begin
            stall_draw = quiet ? 0 : $urandom_range(0, 9);
            out_stall  <= (stall_draw != 0);
            stall_left <= stall_draw;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end
    end

    // Offer one sample word after a random gap and wait until it is taken
    task automatic send_word(input logic signed [SAMPLE_W-1:0] x, input logic st);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid       <= 1'b1;
        noise_sample   <= x;
        start_sequence <= st;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && cycles < CYCLE_LIMIT) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write the order, all weights and the spare index; block must be idle
    task automatic load_config(input logic [TAP_CNT_W-1:0] order);
        logic [CFG_DATA_W-TAP_CNT_W-1:0] upper;
        upper = (CFG_DATA_W-TAP_CNT_W)'($urandom);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_TAP_COUNT;
        cfg_wdata <= {upper, order};
        @(posedge i_clk);
        for (int k = 0; k < COEF_REGS; k++) begin
            cfg_addr  <= REG_COEF_FIRST + CFG_ADDR_W'(k);
            cfg_wdata <= weights_next[k];
            @(posedge i_clk);
        end
        cfg_addr  <= REG_SPARE;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_noise();
        case ($urandom_range(0, 9))
            0:       return NOISE_MAX;
            1:       return NOISE_MIN;
            2, 3:    return SAMPLE_W'($urandom_range(0, 511) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Full range, small weights that rarely clip, or mostly extremes
    function automatic logic signed [COEF_W-1:0] draw_weight(input int mode);
        case (mode)
            0: return COEF_W'($urandom);
            1: return COEF_W'($urandom_range(0, 8191) - 4096);
            default: begin
                case ($urandom_range(0, 2))
                    0:       return COEF_MAX;
                    1:       return COEF_MIN;
                    default: return COEF_W'($urandom_range(0, 3) - 1);
                endcase
            end
        endcase
    endfunction

    initial begin
        int sent;
        int run_len;
        bit lead_start;
        int mode;
        logic [TAP_CNT_W-1:0] order;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: order zero, first word needs no start flag
        send_word(NOISE_MAX, 1'b0);
        send_word(NOISE_MIN, 1'b0);
        send_word('0, 1'b1);
        send_word(-16'sd1, 1'b0);
        drain();

        // Order one with weight one half: rounding of half steps both ways
        foreach (weights_next[k]) weights_next[k] = draw_weight(0);
        weights_next[0] = COEF_HALF;
        load_config(3'd1);
        send_word(16'sd1, 1'b1);
        send_word('0, 1'b0);
        send_word(-16'sd1, 1'b0);
        send_word('0, 1'b0);
        drain();

        // Full order, largest weights: warm-up pass-through then clip high
        foreach (weights_next[k]) weights_next[k] = COEF_MAX;
        load_config(3'd6);
        send_word(NOISE_MAX, 1'b1);
        repeat (6) send_word(NOISE_MAX, 1'b0);
        drain();

        // Order above the delay line, most negative weights: clip low
        foreach (weights_next[k]) weights_next[k] = COEF_MIN;
        load_config(3'd7);
        send_word(NOISE_MAX, 1'b1);
        repeat (6) send_word(NOISE_MAX, 1'b0);
        drain();

        // Random phases: new settings mid-stream, sequences of random length
        for (int p = 0; p < RAND_PHASES; p++) begin
            mode  = p % 3;
            order = (p == 0) ? 3'd6 : 3'($urandom_range(0, 7));
            foreach (weights_next[k]) weights_next[k] = draw_weight(mode);
            load_config(order);
            quiet = (p % 4 == 3);
            sent  = 0;
            while (sent < PHASE_WORDS) begin
                run_len    = $urandom_range(1, 40);
                lead_start = ($urandom_range(0, 7) != 0);
                for (int j = 0; j < run_len; j++) begin
                    send_word(draw_noise(), (j == 0) && lead_start);
                end
                sent += run_len;
            end
            drain();
            quiet = 1'b0;
        end

        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
